// ===== rtl/qct_pkg.sv =====
package qct_pkg;

    localparam int MAX_TOKENS_BOUND = 64;
    localparam int COUNT_W = 7;
    localparam int INDEX_W = 6;
    localparam int KIND_W = 3;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [KIND_W-1:0] KIND_DATA     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_END      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OK       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OVER     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UNCLOSED = 3'd4;

    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_line;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [7:0]         data_byte;
        logic [INDEX_W-1:0] token_index;
        logic [COUNT_W-1:0] token_count;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic               in_token;
        logic               quote_mode;
        logic               quote_is_double;
        logic               escape_pending;
        logic [COUNT_W-1:0] tokens_started;
        logic               overflowed;
    } line_state_t;

endpackage

// ===== rtl/qct_step.sv =====
module qct_step
    import qct_pkg::*;
(
    input  line_state_t        state,
    input  in_item_t           item,
    input  logic [COUNT_W-1:0] max_tokens,
    output line_state_t        state_next,
    output logic [1:0]         num_results,
    output out_item_t          result0,
    output out_item_t          result1
);

    logic [COUNT_W-1:0] limit;
    logic               start_ok;
    logic               is_ws;
    logic               is_quote;
    logic [7:0]         close_ch;
    logic [INDEX_W-1:0] cur_idx;

    assign limit = (max_tokens > COUNT_W'(MAX_TOKENS_BOUND))
                 ? COUNT_W'(MAX_TOKENS_BOUND) : max_tokens;
    assign start_ok = state.tokens_started < limit;
    assign is_ws = (item.ch == CH_SPACE) || (item.ch >= CH_TAB && item.ch <= CH_CR);
    assign is_quote = (item.ch == CH_DQUOTE) || (item.ch == CH_SQUOTE);
    assign close_ch = state.quote_is_double ? CH_DQUOTE : CH_SQUOTE;
    assign cur_idx = (state.tokens_started != '0)
                   ? INDEX_W'(state.tokens_started - COUNT_W'(1)) : '0;

    always_comb
    begin
        logic               handled;
        logic [COUNT_W-1:0] ts_new;
        logic [INDEX_W-1:0] idx_new;
        state_next  = state;
        num_results = 2'd0;
        result0     = '0;
        result1     = '0;
        handled     = 1'b0;
        ts_new      = state.tokens_started;
        idx_new     = cur_idx;
        result0.token_count = state.tokens_started;
        result1.token_count = state.tokens_started;

        if (item.end_of_line)
        begin
            result0.last = 1'b1;
            num_results  = 2'd1;
            if (state.overflowed)
            begin
                result0.kind = KIND_OVER;
            end
            else if (state.in_token)
            begin
                result0.kind        = KIND_END;
                result0.token_index = cur_idx;
                result0.last        = 1'b0;
                result1.kind        = state.quote_mode ? KIND_UNCLOSED : KIND_OK;
                result1.last        = 1'b1;
                num_results         = 2'd2;
            end
            else
            begin
                result0.kind = state.quote_mode ? KIND_UNCLOSED : KIND_OK;
            end
            state_next = '0;
        end
        else if (!state.overflowed)
        begin
            if (!state.escape_pending)
            begin
                if (state.quote_mode)
                begin
                    handled = 1'b1;
                    if (item.ch == close_ch)
                    begin
                        result0.kind        = KIND_END;
                        result0.token_index = cur_idx;
                        result0.last        = 1'b1;
                        num_results         = 2'd1;
                        state_next.quote_mode = 1'b0;
                        state_next.in_token   = 1'b0;
                    end
                    else if (item.ch == CH_BACKSLASH)
                    begin
                        state_next.escape_pending = 1'b1;
                    end
                    else
                    begin
                        result0.kind        = KIND_DATA;
                        result0.data_byte   = item.ch;
                        result0.token_index = cur_idx;
                        result0.last        = 1'b1;
                        num_results         = 2'd1;
                    end
                end
                else if (is_quote && !state.in_token)
                begin
                    handled = 1'b1;
                    if (!start_ok)
                    begin
                        state_next.overflowed = 1'b1;
                    end
                    else
                    begin
                        state_next.tokens_started  = state.tokens_started + COUNT_W'(1);
                        state_next.in_token        = 1'b1;
                        state_next.quote_mode      = 1'b1;
                        state_next.quote_is_double = (item.ch == CH_DQUOTE);
                    end
                end
                else if (is_ws)
                begin
                    handled = 1'b1;
                    if (state.in_token)
                    begin
                        result0.kind        = KIND_END;
                        result0.token_index = cur_idx;
                        result0.last        = 1'b1;
                        num_results         = 2'd1;
                        state_next.in_token = 1'b0;
                    end
                end
            end

            // plain character, or the one after a backslash
            if (!handled)
            begin
                if (!state.in_token && !start_ok)
                begin
                    state_next.overflowed = 1'b1;
                end
                else
                begin
                    if (!state.in_token)
                    begin
                        ts_new = state.tokens_started + COUNT_W'(1);
                        state_next.tokens_started = ts_new;
                        state_next.in_token       = 1'b1;
                        idx_new = INDEX_W'(state.tokens_started);
                    end
                    if (item.ch == CH_BACKSLASH && !state.escape_pending)
                    begin
                        state_next.escape_pending = 1'b1;
                    end
                    else
                    begin
                        state_next.escape_pending = 1'b0;
                        result0.kind        = KIND_DATA;
                        result0.data_byte   = item.ch;
                        result0.token_index = idx_new;
                        result0.token_count = ts_new;
                        result0.last        = 1'b1;
                        num_results         = 2'd1;
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/qct_outq.sv =====
module qct_outq
    import qct_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_num,
    input  out_item_t         push0,
    input  out_item_t         push1,
    input  logic              pop,
    output logic              room2,
    output logic              head_valid,
    output out_item_t         head,
    output logic [QCNT_W-1:0] count
);

    out_item_t          mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_pop;

    assign do_pop      = pop && (count_reg != '0);
    assign wr_ptr_next = wr_ptr_reg + QPTR_W'(push_num);
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(do_pop);
    assign count_next  = count_reg + QCNT_W'(push_num) - QCNT_W'(do_pop);

    assign room2      = count_reg <= QCNT_W'(QDEPTH - 2);
    assign head_valid = count_reg != '0;
    assign head       = mem[rd_ptr_reg];
    assign count      = count_reg;

    always_ff @(posedge clk)
    begin
        if (push_num != 2'd0)
            mem[wr_ptr_reg] <= push0;
        if (push_num == 2'd2)
            mem[wr_ptr_reg + QPTR_W'(1)] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/quoted_command_tokenizer.sv =====
// channel  | direction | payload    | handshake
// in       | input     | in_item_t  | in_valid / in_stall
// out      | output    | out_item_t | out_valid / out_stall
// cfg      | input     | max_tokens | cfg_write / cfg_data
//
// one character per cycle sustained while the result queue has room for two; a beat
// goes from the input register through the step logic into the result queue
// end of line inside a token gives two results, the queue absorbs the extra
// one; input stalls only while the four-entry result queue has under two free
// reset clears line state and sets max_tokens to 64; no clearing pass
module quoted_command_tokenizer
    import qct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_item_t           in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_item,
    input  logic               cfg_write,
    input  logic [COUNT_W-1:0] cfg_data
);

    logic               in_valid_reg;
    logic               in_valid_next;
    in_item_t           in_item_reg;
    line_state_t        state_reg;
    line_state_t        state_next;
    logic [COUNT_W-1:0] max_tokens_reg;
    logic               room2;
    logic               process;
    logic               in_accept;
    logic [1:0]         num_results;
    logic [1:0]         push_num;
    out_item_t          result0;
    out_item_t          result1;
    logic [QCNT_W-1:0]  q_count;

    assign process       = in_valid_reg && room2;
    assign in_stall      = in_valid_reg && !room2;
    assign in_accept     = in_valid && !in_stall;
    assign in_valid_next = in_accept || (in_valid_reg && !process);
    assign push_num      = process ? num_results : 2'd0;

    qct_step u_step (
        .state       (state_reg),
        .item        (in_item_reg),
        .max_tokens  (max_tokens_reg),
        .state_next  (state_next),
        .num_results (num_results),
        .result0     (result0),
        .result1     (result1)
    );

    qct_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_num   (push_num),
        .push0      (result0),
        .push1      (result1),
        .pop        (!out_stall),
        .room2      (room2),
        .head_valid (out_valid),
        .head       (out_item),
        .count      (q_count)
    );

    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_item_reg <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            state_reg      <= '0;
            max_tokens_reg <= COUNT_W'(MAX_TOKENS_BOUND);
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (process)
                state_reg <= state_next;
            if (cfg_write)
                max_tokens_reg <= cfg_data;
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCNT_W'(QDEPTH))
        else $error("result queue count beyond depth");

    a_room_on_process: assert property (@(posedge clk) disable iff (!rst_n)
        process |-> q_count <= QCNT_W'(QDEPTH - 2))
        else $error("beat processed without room for two results");

    a_tokens_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.tokens_started <= COUNT_W'(MAX_TOKENS_BOUND))
        else $error("token count beyond bound");

    a_overflow_unquoted: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.overflowed |-> !state_reg.quote_mode)
        else $error("overflow while in a quote");

    a_escape_in_token: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.escape_pending |-> state_reg.in_token)
        else $error("escape pending outside a token");

endmodule
